// File: rtl/core/lst_pkg.sv
// Package for the LRU size tracker: request and response payload structs,
// request and status codes, and the total limit. No dependencies.
package lst_pkg;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 32;
    localparam int TOTAL_W = 40;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [1:0] REQ_ACCESS = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_EVICT  = 2'd2;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EVICTED   = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] item_size;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [TOTAL_W-1:0] total_size;
        logic [KEY_W-1:0]   evicted_key;
    } t_rsp;

endpackage

// File: rtl/core/lru_size_tracker_top.sv
// LRU size tracker: keyed entries in recency order with byte sizes and a
// saturating running total. Depends on lst_pkg for payload types and codes.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------
//  request | in        | i_in_valid / o_in_ready    | i_in_data  (t_req)
//  result  | out       | o_out_valid / i_out_ready  | o_out_data (t_rsp)
//
// One request at a time. A request scans all ENTRIES slots through the memory
// read port and, when it changes the table, sweeps the rank memory again
// read-modify-write; when nothing changes it goes straight to its result.
// After reset a clearing pass writes the valid bits to zero before the first
// request is taken. A result waits in the output register; the next request
// is taken meanwhile and stalls only at its own result.
module lru_size_tracker_top #(
    parameter int ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lst_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lst_pkg::t_rsp o_out_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

    typedef struct packed {
        logic          vld;
        logic [AW-1:0] rank;
    } t_meta;

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_SWEEP  = 8'b0001_0000,
        S_SUB    = 8'b0010_0000,
        S_ADD    = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        ACT_HIT    = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DROP   = 2'd2
    } t_act;

    // Memories and their registered read data.
    logic [lst_pkg::KEY_W-1:0]  r_key_mem  [ENTRIES];
    logic [lst_pkg::SIZE_W-1:0] r_size_mem [ENTRIES];
    t_meta                      r_meta_mem [ENTRIES];
    logic [lst_pkg::KEY_W-1:0]  r_key_q;
    logic [lst_pkg::SIZE_W-1:0] r_size_q;
    t_meta                      r_meta_q;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_addr;
    logic                         r_issue_done;
    logic                         r_rd_vld;
    logic [AW-1:0]                r_rd_idx;
    lst_pkg::t_req                r_req;
    logic [lst_pkg::TOTAL_W-1:0]  r_total;

    // Scan results.
    logic                         r_found;
    logic [AW-1:0]                r_slot;
    logic [AW-1:0]                r_slot_rank;
    logic [lst_pkg::SIZE_W-1:0]   r_slot_size;
    logic                         r_free_found;
    logic [AW-1:0]                r_free_slot;
    logic                         r_old_found;
    logic [AW-1:0]                r_old_slot;
    logic [AW-1:0]                r_old_rank;
    logic [lst_pkg::SIZE_W-1:0]   r_old_size;
    logic [lst_pkg::KEY_W-1:0]    r_old_key;

    // Decided action.
    t_act                         r_act;
    logic [AW-1:0]                r_tgt;
    logic [AW-1:0]                r_ref;
    logic [lst_pkg::SIZE_W-1:0]   r_sub_val;
    logic                         r_do_sub;
    logic                         r_do_add;
    logic [2:0]                   r_status;
    logic [lst_pkg::KEY_W-1:0]    r_evk;

    lst_pkg::t_rsp                r_out;
    logic                         r_out_vld;

    logic                         w_accept;
    logic                         w_rd_en;
    logic                         w_meta_we;
    logic [AW-1:0]                w_meta_wa;
    t_meta                        w_meta_wd;
    t_meta                        w_sweep_meta;
    logic                         w_ks_we;
    logic                         w_last_data;

    logic [2:0]                   w_status;
    t_act                         w_act;
    logic                         w_change;
    logic [AW-1:0]                w_tgt;
    logic [AW-1:0]                w_ref;
    logic [lst_pkg::SIZE_W-1:0]   w_sub_val;
    logic                         w_do_sub;
    logic                         w_do_add;
    logic [lst_pkg::KEY_W-1:0]    w_evk;

    logic [lst_pkg::TOTAL_W:0]    w_sum;
    logic [lst_pkg::TOTAL_W-1:0]  w_sub_ext;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_rd_en     = (r_state == S_SCAN || r_state == S_SWEEP) && !r_issue_done;
    assign w_last_data = r_rd_vld && (r_rd_idx == LAST);
    assign w_ks_we     = (r_state == S_DECIDE) && w_change && (w_act != ACT_DROP);

    // Decision from the scan results.
    always_comb begin
        w_status  = lst_pkg::ST_NOT_FOUND;
        w_act     = ACT_DROP;
        w_change  = 1'b0;
        w_tgt     = r_slot;
        w_ref     = r_slot_rank;
        w_sub_val = r_slot_size;
        w_do_sub  = 1'b0;
        w_do_add  = 1'b0;
        w_evk     = '0;
        case (r_req.req_type)
            lst_pkg::REQ_ACCESS: begin
                if (r_found) begin
                    w_status = lst_pkg::ST_HIT;
                    w_act    = ACT_HIT;
                    w_change = 1'b1;
                    w_do_sub = 1'b1;
                    w_do_add = 1'b1;
                end else if (r_free_found) begin
                    w_status = lst_pkg::ST_INSERTED;
                    w_act    = ACT_INSERT;
                    w_change = 1'b1;
                    w_tgt    = r_free_slot;
                    w_do_add = 1'b1;
                end else begin
                    w_status = lst_pkg::ST_FULL;
                end
            end
            lst_pkg::REQ_REMOVE: begin
                if (r_found) begin
                    w_status = lst_pkg::ST_REMOVED;
                    w_change = 1'b1;
                    w_do_sub = 1'b1;
                end
            end
            lst_pkg::REQ_EVICT: begin
                if (r_old_found) begin
                    w_status  = lst_pkg::ST_EVICTED;
                    w_change  = 1'b1;
                    w_tgt     = r_old_slot;
                    w_ref     = r_old_rank;
                    w_sub_val = r_old_size;
                    w_do_sub  = 1'b1;
                    w_evk     = r_old_key;
                end else begin
                    w_status = lst_pkg::ST_EMPTY;
                end
            end
            default: begin
                w_status = lst_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // New rank and valid bit of the slot whose meta data just came back.
    always_comb begin
        w_sweep_meta = r_meta_q;
        if (r_rd_idx == r_tgt) begin
            case (r_act)
                ACT_HIT, ACT_INSERT: w_sweep_meta = '{vld: 1'b1, rank: '0};
                default:             w_sweep_meta.vld = 1'b0;
            endcase
        end else if (r_meta_q.vld) begin
            case (r_act)
                ACT_HIT: begin
                    if (r_meta_q.rank < r_ref) w_sweep_meta.rank = r_meta_q.rank + AW'(1);
                end
                ACT_INSERT: w_sweep_meta.rank = r_meta_q.rank + AW'(1);
                default: begin
                    if (r_meta_q.rank > r_ref) w_sweep_meta.rank = r_meta_q.rank - AW'(1);
                end
            endcase
        end
    end

    always_comb begin
        w_meta_we = 1'b0;
        w_meta_wa = r_rd_idx;
        w_meta_wd = w_sweep_meta;
        if (r_state == S_CLEAR) begin
            w_meta_we = 1'b1;
            w_meta_wa = r_addr;
            w_meta_wd = '0;
        end else if (r_state == S_SWEEP && r_rd_vld) begin
            w_meta_we = 1'b1;
        end
    end

    assign w_sum     = {1'b0, r_total}
                     + {{(lst_pkg::TOTAL_W + 1 - lst_pkg::SIZE_W){1'b0}}, r_req.item_size};
    assign w_sub_ext = {{(lst_pkg::TOTAL_W - lst_pkg::SIZE_W){1'b0}}, r_sub_val};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_addr == LAST) n_state = S_IDLE;
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (w_last_data) n_state = S_DECIDE;
            S_DECIDE: n_state = w_change ? S_SWEEP : S_DONE;
            S_SWEEP:  if (w_last_data) n_state = S_SUB;
            S_SUB:    n_state = S_ADD;
            S_ADD:    n_state = S_DONE;
            S_DONE:   if (!r_out_vld || i_out_ready) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Memory ports: one write and one registered read per array.
    always_ff @(posedge i_clk) begin
        if (w_meta_we) r_meta_mem[w_meta_wa] <= w_meta_wd;
        if (w_ks_we) begin
            r_key_mem[w_tgt]  <= r_req.key;
            r_size_mem[w_tgt] <= r_req.item_size;
        end
        if (w_rd_en) begin
            r_key_q  <= r_key_mem[r_addr];
            r_size_q <= r_size_mem[r_addr];
            r_meta_q <= r_meta_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_total      <= '0;
            r_out_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_old_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            r_rd_idx <= r_addr;

            if (r_state == S_CLEAR) begin
                r_addr <= (r_addr == LAST) ? '0 : r_addr + AW'(1);
            end else if (w_rd_en) begin
                if (r_addr == LAST) r_issue_done <= 1'b1;
                else                r_addr       <= r_addr + AW'(1);
            end

            if (w_accept) begin
                r_req        <= i_in_data;
                r_addr       <= '0;
                r_issue_done <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_old_found  <= 1'b0;
            end

            if (r_state == S_SCAN && r_rd_vld) begin
                if (r_meta_q.vld && r_key_q == r_req.key && !r_found) begin
                    r_found     <= 1'b1;
                    r_slot      <= r_rd_idx;
                    r_slot_rank <= r_meta_q.rank;
                    r_slot_size <= r_size_q;
                end
                if (!r_meta_q.vld && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_slot  <= r_rd_idx;
                end
                if (r_meta_q.vld && (!r_old_found || r_meta_q.rank > r_old_rank)) begin
                    r_old_found <= 1'b1;
                    r_old_slot  <= r_rd_idx;
                    r_old_rank  <= r_meta_q.rank;
                    r_old_size  <= r_size_q;
                    r_old_key   <= r_key_q;
                end
            end

            if (r_state == S_DECIDE) begin
                r_act        <= w_act;
                r_tgt        <= w_tgt;
                r_ref        <= w_ref;
                r_sub_val    <= w_sub_val;
                r_do_sub     <= w_do_sub;
                r_do_add     <= w_do_add;
                r_status     <= w_status;
                r_evk        <= w_evk;
                r_addr       <= '0;
                r_issue_done <= 1'b0;
            end

            // Subtraction floors at zero; addition saturates at the maximum.
            if (r_state == S_SUB && r_do_sub) begin
                r_total <= (r_total < w_sub_ext) ? '0 : r_total - w_sub_ext;
            end
            if (r_state == S_ADD && r_do_add) begin
                r_total <= w_sum[lst_pkg::TOTAL_W] ? lst_pkg::TOTAL_MAX
                                                   : w_sum[lst_pkg::TOTAL_W-1:0];
            end

            if (r_state == S_DONE && (!r_out_vld || i_out_ready)) begin
                r_out_vld         <= 1'b1;
                r_out.status      <= r_status;
                r_out.total_size  <= r_total;
                r_out.evicted_key <= r_evk;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SCAN)
        else $error("accepted request did not start a scan");

    a_evk_only_on_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status != lst_pkg::ST_EVICTED) |-> r_out.evicted_key == '0)
        else $error("evicted key set on a result that is not an eviction");

    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && r_rd_vld && w_rd_en) |-> r_addr != r_rd_idx)
        else $error("sweep read and write hit the same slot");

    a_total_only_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SUB && r_state != S_ADD) |=> $stable(r_total))
        else $error("total changed outside its update states");

endmodule

// File: tb/sv/lru_size_tracker_top_tb.sv
// Self-checking testbench for lru_size_tracker_top: drives request transfers,
// predicts each result with its own recency table, and checks every result.
// Depends on lst_pkg and the lru_size_tracker_top RTL.
module lru_size_tracker_top_tb;

    localparam int SLOTS       = 16;
    localparam int POOL_KEYS   = 24;
    localparam int LONG_STALL  = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 2 * SLOTS + 20;
    localparam int PAD_W       = lst_pkg::TOTAL_W - lst_pkg::SIZE_W;

    // Request type that no operation uses; the block answers it as not found.
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    lst_pkg::t_req i_in_data   = '0;
    logic          i_out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    lst_pkg::t_rsp o_out_data;

    lru_size_tracker_top #(
        .ENTRIES(SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Predicted table contents.
    logic [lst_pkg::KEY_W-1:0]   key_tag [SLOTS];
    logic [lst_pkg::SIZE_W-1:0]  item_bytes [SLOTS];
    logic                        slot_used [SLOTS];
    int                          slot_rank [SLOTS];
    logic [lst_pkg::TOTAL_W-1:0] bytes_held;

    lst_pkg::t_req             pending_req [$];
    lst_pkg::t_rsp             expected_rsp [$];
    logic [lst_pkg::KEY_W-1:0] key_pool [POOL_KEYS];

    int send_idle_pct = 21;
    int recv_idle_pct = 84;
    int stall_asks    = 0;
    int stall_seen    = 0;
    int hold_left     = 0;
    int sent_count    = 0;
    int recv_count    = 0;
    int mismatches    = 0;
    int status_seen [8];

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void add_bytes(logic [lst_pkg::SIZE_W-1:0] v);
        logic [lst_pkg::TOTAL_W-1:0] v_ext;
        v_ext = {{PAD_W{1'b0}}, v};
        if (bytes_held > lst_pkg::TOTAL_MAX - v_ext) begin
            bytes_held = lst_pkg::TOTAL_MAX;
        end else begin
            bytes_held = bytes_held + v_ext;
        end
    endfunction

    function automatic void sub_bytes(logic [lst_pkg::SIZE_W-1:0] v);
        logic [lst_pkg::TOTAL_W-1:0] v_ext;
        v_ext = {{PAD_W{1'b0}}, v};
        if (bytes_held < v_ext) begin
            bytes_held = '0;
        end else begin
            bytes_held = bytes_held - v_ext;
        end
    endfunction

    // Entries older than the dropped one each move one rank closer to the front.
    function automatic void drop_entry(int s);
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && slot_rank[i] > slot_rank[s]) begin
                slot_rank[i]--;
            end
        end
        slot_used[s] = 1'b0;
        sub_bytes(item_bytes[s]);
    endfunction

    function automatic lst_pkg::t_rsp predict_response(lst_pkg::t_req rq);
        lst_pkg::t_rsp rsp;
        int            hit_slot;
        int            free_slot;
        int            oldest_slot;
        rsp.status      = lst_pkg::ST_NOT_FOUND;
        rsp.evicted_key = '0;
        hit_slot        = -1;
        free_slot       = -1;
        oldest_slot     = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && key_tag[i] == rq.key && hit_slot < 0) begin
                hit_slot = i;
            end
            if (!slot_used[i] && free_slot < 0) begin
                free_slot = i;
            end
            if (slot_used[i] && (oldest_slot < 0 || slot_rank[i] > slot_rank[oldest_slot])) begin
                oldest_slot = i;
            end
        end
        case (rq.req_type)
            lst_pkg::REQ_ACCESS: begin
                if (hit_slot >= 0) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i] && slot_rank[i] < slot_rank[hit_slot]) begin
                            slot_rank[i]++;
                        end
                    end
                    slot_rank[hit_slot] = 0;
                    sub_bytes(item_bytes[hit_slot]);
                    item_bytes[hit_slot] = rq.item_size;
                    add_bytes(rq.item_size);
                    rsp.status = lst_pkg::ST_HIT;
                end else if (free_slot < 0) begin
                    rsp.status = lst_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_used[i]) begin
                            slot_rank[i]++;
                        end
                    end
                    slot_used[free_slot]  = 1'b1;
                    key_tag[free_slot]    = rq.key;
                    item_bytes[free_slot] = rq.item_size;
                    slot_rank[free_slot]  = 0;
                    add_bytes(rq.item_size);
                    rsp.status = lst_pkg::ST_INSERTED;
                end
            end
            lst_pkg::REQ_REMOVE: begin
                if (hit_slot >= 0) begin
                    drop_entry(hit_slot);
                    rsp.status = lst_pkg::ST_REMOVED;
                end
            end
            lst_pkg::REQ_EVICT: begin
                if (oldest_slot < 0) begin
                    rsp.status = lst_pkg::ST_EMPTY;
                end else begin
                    rsp.evicted_key = key_tag[oldest_slot];
                    drop_entry(oldest_slot);
                    rsp.status = lst_pkg::ST_EVICTED;
                end
            end
            default: begin
            end
        endcase
        rsp.total_size = bytes_held;
        status_seen[rsp.status]++;
        return rsp;
    endfunction

    function automatic logic [lst_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic lst_pkg::t_req make_req(logic [1:0] kind,
                                               logic [lst_pkg::KEY_W-1:0] k,
                                               logic [lst_pkg::SIZE_W-1:0] sz);
        lst_pkg::t_req rq;
        rq.req_type  = kind;
        rq.key       = k;
        rq.item_size = sz;
        return rq;
    endfunction

    // Random traffic in bursts: mixed requests, fill runs that push the table
    // to full, and drain runs that empty it again.
    task automatic add_random_requests(input int count);
        int added;
        int burst;
        int burst_len;
        int r;
        logic [lst_pkg::KEY_W-1:0] pool_key;
        logic [lst_pkg::KEY_W-1:0] fresh_key;
        added = 0;
        while (added < count) begin
            burst     = $urandom_range(9);
            burst_len = $urandom_range(4, 20);
            for (int j = 0; j < burst_len && added < count; j++) begin
                r         = $urandom_range(99);
                pool_key  = key_pool[$urandom_range(POOL_KEYS - 1)];
                fresh_key = {$urandom, $urandom};
                if (burst < 5) begin
                    if (r < 50) begin
                        pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, pool_key,
                                                       pick_size()));
                    end else if (r < 60) begin
                        pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, fresh_key,
                                                       pick_size()));
                    end else if (r < 75) begin
                        pending_req.push_back(make_req(lst_pkg::REQ_REMOVE, pool_key,
                                                       $urandom));
                    end else if (r < 80) begin
                        pending_req.push_back(make_req(lst_pkg::REQ_REMOVE, fresh_key,
                                                       $urandom));
                    end else if (r < 95) begin
                        pending_req.push_back(make_req(lst_pkg::REQ_EVICT, fresh_key,
                                                       $urandom));
                    end else begin
                        pending_req.push_back(make_req(REQ_RESERVED, fresh_key, $urandom));
                    end
                end else if (burst < 8) begin
                    pending_req.push_back(make_req(lst_pkg::REQ_ACCESS,
                                                   (r < 50) ? pool_key : fresh_key,
                                                   pick_size()));
                end else if (r < 60) begin
                    pending_req.push_back(make_req(lst_pkg::REQ_EVICT, fresh_key, $urandom));
                end else begin
                    pending_req.push_back(make_req(lst_pkg::REQ_REMOVE, pool_key, $urandom));
                end
                added++;
            end
        end
    endtask

    // The sender holds off until every expected result has arrived.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_req.size() != 0 || i_in_valid || expected_rsp.size() != 0);
    endtask

    // Request driver.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_rsp.push_back(predict_response(i_in_data));
            sent_count++;
        end
        if (!i_in_valid || o_in_ready) begin
            if (i_rst_n && pending_req.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_req.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver ready.
    always @(posedge i_clk) begin
        lst_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            recv_count++;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: status %0d total %0d evicted %h",
                             o_out_data.status, o_out_data.total_size,
                             o_out_data.evicted_key);
                end
            end else begin
                want = expected_rsp.pop_front();
                if (o_out_data.status !== want.status
                        || o_out_data.total_size !== want.total_size
                        || o_out_data.evicted_key !== want.evicted_key) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result %0d: expected %0d/%0d/%h, got %0d/%0d/%h",
                                 recv_count, want.status, want.total_size, want.evicted_key,
                                 o_out_data.status, o_out_data.total_size,
                                 o_out_data.evicted_key);
                    end
                end
            end
        end
        if (stall_asks != stall_seen) begin
            stall_seen = stall_asks;
            hold_left  = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else if (i_rst_n) begin
                quiet++;
            end
        end
        $display("Timeout after %0d quiet cycles", QUIET_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            slot_used[i]  = 1'b0;
            key_tag[i]    = '0;
            item_bytes[i] = '0;
            slot_rank[i]  = 0;
        end
        for (int i = 0; i < 8; i++) begin
            status_seen[i] = 0;
        end
        bytes_held  = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_KEYS; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table cases, key and size extremes, a hit, then a
        // fill to capacity and one insert beyond it.
        pending_req.push_back(make_req(lst_pkg::REQ_EVICT, '1, '1));
        pending_req.push_back(make_req(lst_pkg::REQ_REMOVE, key_pool[5], '0));
        pending_req.push_back(make_req(REQ_RESERVED, '1, '1));
        pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, '0, '0));
        pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, '1, '1));
        pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, '0, '1));
        pending_req.push_back(make_req(lst_pkg::REQ_REMOVE, '1, '0));
        pending_req.push_back(make_req(lst_pkg::REQ_EVICT, '0, '0));
        for (int i = 2; i < 2 + SLOTS; i++) begin
            pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, key_pool[i], pick_size()));
        end
        pending_req.push_back(make_req(lst_pkg::REQ_ACCESS, key_pool[2 + SLOTS], '1));
        wait_drained();

        add_random_requests(140);
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 21;
        add_random_requests(140);
        wait_drained();

        // No idling; the receiver first holds off long enough that the block
        // fills its result register and stops taking requests.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_requests(145);
        stall_asks++;
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        mismatches += expected_rsp.size();
        $display("Covered %0d requests and %0d results: %0d hits, %0d inserts, %0d removes,",
                 sent_count, recv_count, status_seen[lst_pkg::ST_HIT],
                 status_seen[lst_pkg::ST_INSERTED], status_seen[lst_pkg::ST_REMOVED]);
        $display("%0d evictions, %0d empty, %0d table full, %0d not found; %0d mismatches.",
                 status_seen[lst_pkg::ST_EVICTED], status_seen[lst_pkg::ST_EMPTY],
                 status_seen[lst_pkg::ST_FULL], status_seen[lst_pkg::ST_NOT_FOUND],
                 mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
